FILE: hw/rtl/icw_pkg.sv
// Package with the widths, codes and shared types of the interval cover window filter.
`default_nettype none

package icw_pkg;

    localparam int MODE_W          = 2;
    localparam int TIME_IN_W       = 34;
    localparam int DUR_W           = 24;
    localparam int ID_W            = 16;
    localparam int IDX_W           = 20;
    localparam int WSEC_W          = 16;
    localparam int SLOT_W          = 21;
    localparam int STAT_W          = 2;
    localparam int PROD_W          = 36;
    localparam int END_W           = 35;
    localparam int TIME_W          = 37;
    localparam int DATA_W          = 64;
    localparam int PADDR_W         = 5;
    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [WSEC_W-1:0] WSEC_RESET = WSEC_W'(30);

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_QUERY  = 2'd2
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_code_t;

    typedef enum logic [1:0] {
        REG_BEGIN  = 2'd0,
        REG_WSEC   = 2'd1,
        REG_WCOUNT = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT_ONE,
        S_MUL,
        S_ADD_LO,
        S_ADD_HI,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [TIME_IN_W-1:0] begin_second;
        logic [WSEC_W-1:0]    window_seconds;
        logic [IDX_W-1:0]     window_count;
    } cfg_t;

    typedef struct packed {
        logic [TIME_IN_W-1:0] start;
        logic [DUR_W-1:0]     duration;
        logic [ID_W-1:0]      from_id;
        logic [ID_W-1:0]      to_id;
    } entry_t;

    typedef struct packed {
        logic         in_ready;
        logic         accept;
        status_code_t one_status;
        logic         clear_count;
        logic         append;
        logic         mul;
        logic         add_lo;
        logic         add_hi;
        logic         advance;
        logic         push_mid;
        logic         push_one;
        logic         push_final;
    } ctrl_cmd_t;

    typedef struct packed {
        logic              in_valid;
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              range_err;
        logic              empty;
        logic              hit;
        logic              pend_valid;
        logic              last_entry;
        logic              out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/icw_item_if.sv
// Input channel interface carrying one request word.
`default_nettype none

interface icw_item_if
    import icw_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [TIME_IN_W-1:0] start_second;
    logic [DUR_W-1:0]     duration_seconds;
    logic [ID_W-1:0]      from_id;
    logic [ID_W-1:0]      to_id;
    logic [IDX_W-1:0]     window_index;

    modport source (
        output valid, mode, start_second, duration_seconds, from_id, to_id, window_index,
        input  ready
    );

    modport sink (
        input  valid, mode, start_second, duration_seconds, from_id, to_id, window_index,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/icw_result_if.sv
// Output channel interface carrying one result word.
`default_nettype none

interface icw_result_if
    import icw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              match;
    logic [ID_W-1:0]   party_from;
    logic [ID_W-1:0]   party_to;
    logic [SLOT_W-1:0] slot_number;
    logic [STAT_W-1:0] status;
    logic              last;

    modport source (
        output valid, match, party_from, party_to, slot_number, status, last,
        input  ready
    );

    modport sink (
        input  valid, match, party_from, party_to, slot_number, status, last,
        output ready
    );
endinterface

`default_nettype wire

FILE: hw/rtl/icw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module icw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/icw_regs.sv
// APB configuration registers for window start, window length and window count.
`default_nettype none

module icw_regs
    import icw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t sel;
    logic       wr_en;

    assign sel    = reg_index_t'(paddr[4:3]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel)
                REG_BEGIN:  cfg_next.begin_second   = pwdata[TIME_IN_W-1:0];
                REG_WSEC:   cfg_next.window_seconds = pwdata[WSEC_W-1:0];
                REG_WCOUNT: cfg_next.window_count   = pwdata[IDX_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_BEGIN:  prdata = DATA_W'(cfg_reg.begin_second);
            REG_WSEC:   prdata = DATA_W'(cfg_reg.window_seconds);
            REG_WCOUNT: prdata = DATA_W'(cfg_reg.window_count);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.begin_second   <= '0;
            cfg_reg.window_seconds <= WSEC_RESET;
            cfg_reg.window_count   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/icw_ctrl.sv
// Controller state machine that sequences clear, append and query requests.
`default_nettype none

module icw_ctrl
    import icw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  dp_status_t      st,
    output ctrl_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (st.in_valid)
                begin
                    cmd.accept = 1'b1;
                    case (st.mode)
                        MODE_CLEAR:
                        begin
                            cmd.clear_count = 1'b1;
                            cmd.one_status  = STAT_OK;
                            state_next      = S_EMIT_ONE;
                        end
                        MODE_APPEND:
                        begin
                            if (st.full)
                            begin
                                cmd.one_status = STAT_FULL;
                            end
                            else
                            begin
                                cmd.append     = 1'b1;
                                cmd.one_status = STAT_OK;
                            end
                            state_next = S_EMIT_ONE;
                        end
                        MODE_QUERY:
                        begin
                            if (st.range_err)
                            begin
                                cmd.one_status = STAT_RANGE;
                                state_next     = S_EMIT_ONE;
                            end
                            else if (st.empty)
                            begin
                                cmd.one_status = STAT_OK;
                                state_next     = S_EMIT_ONE;
                            end
                            else
                            begin
                                state_next = S_MUL;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT_ONE:
            begin
                if (st.out_free)
                begin
                    cmd.push_one = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD_LO;
            end
            S_ADD_LO:
            begin
                cmd.add_lo = 1'b1;
                state_next = S_ADD_HI;
            end
            S_ADD_HI:
            begin
                cmd.add_hi = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // A second hit can only move on once the held hit has left.
                if (!(st.hit && st.pend_valid && !st.out_free))
                begin
                    cmd.advance  = 1'b1;
                    cmd.push_mid = st.hit && st.pend_valid;
                    if (st.last_entry)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.push_final = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/icw_datapath.sv
// Datapath with the interaction table, window bound arithmetic and output register.
`default_nettype none

module icw_datapath
    import icw_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  cfg_t              cfg,
    input  ctrl_cmd_t         cmd,
    output dp_status_t        st,
    icw_item_if.sink          item,
    icw_result_if.source      result
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $bits(entry_t);

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [IDX_W-1:0]  idx_reg;
    status_code_t      one_status_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [TIME_W-1:0] t_lo_reg;
    logic [TIME_W-1:0] t_hi_reg;
    logic [AW-1:0]     scan_idx_reg;
    logic [AW-1:0]     scan_idx_next;
    logic              pend_valid_reg;
    logic [ID_W-1:0]   pend_from_reg;
    logic [ID_W-1:0]   pend_to_reg;

    logic              out_valid_reg;
    logic              out_match_reg;
    logic [ID_W-1:0]   out_from_reg;
    logic [ID_W-1:0]   out_to_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    status_code_t      out_status_reg;
    logic              out_last_reg;

    entry_t            wr_entry;
    entry_t            rd_entry;
    logic [EW-1:0]     rd_data;
    logic [AW-1:0]     rd_addr;
    logic [END_W-1:0]  entry_end;
    logic              push_any;
    logic [SLOT_W-1:0] slot;

    assign wr_entry.start    = item.start_second;
    assign wr_entry.duration = item.duration_seconds;
    assign wr_entry.from_id  = item.from_id;
    assign wr_entry.to_id    = item.to_id;

    assign scan_idx_next = scan_idx_reg + AW'(1);
    assign rd_addr       = cmd.advance ? scan_idx_next : scan_idx_reg;

    icw_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_entry  = entry_t'(rd_data);
    assign entry_end = END_W'(rd_entry.start) + END_W'(rd_entry.duration);
    assign slot      = SLOT_W'(idx_reg) + SLOT_W'(1);
    assign push_any  = cmd.push_mid || cmd.push_one || cmd.push_final;

    assign item.ready   = cmd.in_ready;
    assign st.in_valid  = item.valid;
    assign st.mode      = item.mode;
    assign st.full      = (count_reg == CW'(TABLE_DEPTH));
    assign st.range_err = (item.window_index >= cfg.window_count);
    assign st.empty     = (count_reg == '0);
    assign st.hit       = (TIME_W'(rd_entry.start) <= t_lo_reg)
                          && (TIME_W'(entry_end) >= t_hi_reg);
    assign st.pend_valid = pend_valid_reg;
    assign st.last_entry = ((CW'(scan_idx_reg) + CW'(1)) == count_reg);
    assign st.out_free   = !out_valid_reg || result.ready;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear_count)
        begin
            count_next = '0;
        end
        else if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.add_lo)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.advance && st.hit)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (push_any)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg        <= item.window_index;
            one_status_reg <= cmd.one_status;
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(idx_reg) * PROD_W'(cfg.window_seconds);
        end
        if (cmd.add_lo)
        begin
            t_lo_reg     <= TIME_W'(cfg.begin_second) + TIME_W'(prod_reg);
            scan_idx_reg <= '0;
        end
        if (cmd.add_hi)
        begin
            t_hi_reg <= t_lo_reg + TIME_W'(cfg.window_seconds);
        end
        if (cmd.advance)
        begin
            scan_idx_reg <= scan_idx_next;
            if (st.hit)
            begin
                pend_from_reg <= rd_entry.from_id;
                pend_to_reg   <= rd_entry.to_id;
            end
        end
        if (cmd.push_mid)
        begin
            out_match_reg  <= 1'b1;
            out_from_reg   <= pend_from_reg;
            out_to_reg     <= pend_to_reg;
            out_slot_reg   <= slot;
            out_status_reg <= STAT_OK;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.push_final)
        begin
            out_match_reg  <= pend_valid_reg;
            out_from_reg   <= pend_valid_reg ? pend_from_reg : '0;
            out_to_reg     <= pend_valid_reg ? pend_to_reg : '0;
            out_slot_reg   <= pend_valid_reg ? slot : '0;
            out_status_reg <= STAT_OK;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.push_one)
        begin
            out_match_reg  <= 1'b0;
            out_from_reg   <= '0;
            out_to_reg     <= '0;
            out_slot_reg   <= '0;
            out_status_reg <= one_status_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.match       = out_match_reg;
    assign result.party_from  = out_from_reg;
    assign result.party_to    = out_to_reg;
    assign result.slot_number = out_slot_reg;
    assign result.status      = out_status_reg;
    assign result.last        = out_last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/interval_cover_window_filter_top.sv
// Top level of the interval cover window filter.
`default_nettype none

// The block keeps a table of up to TABLE_DEPTH interactions and answers window
// queries against it. A clear or an append is accepted in the idle state, and its
// single result word is loaded into the output register from the emit state once
// the output is free. A query is accepted in the idle state and computes the window
// bounds with one multiply and two adds; it then reads the table RAM at one entry
// per cycle while no downstream stall holds the scan, and loads the final word in
// the finish state once the output is free. An out-of-range query or a query on an
// empty table is answered with a single word like an append. Each covering entry
// gives one result word in table order, with last set on the final word of the
// request.

module interval_cover_window_filter_top
    import icw_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    icw_item_if.sink                item,
    icw_result_if.source            result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t st;

    icw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    icw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    icw_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cmd    (cmd),
        .st     (st),
        .item   (item),
        .result (result)
    );

    // The output register is only loaded when it is empty or being drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_mid || cmd.push_one || cmd.push_final) |-> st.out_free)
        else $error("result word loaded over an untaken word");

    // A full table is never written.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> !st.full)
        else $error("append issued to a full table");

    // An in-range query on a non-empty table starts the bound computation next.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && st.mode == MODE_QUERY && !st.range_err && !st.empty) |=> cmd.mul)
        else $error("query did not start the window bound computation");

    // A scan step never coincides with a single-word result.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> !cmd.push_one && !cmd.push_final)
        else $error("scan step overlapped a single result");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the interval cover window filter: directed table, then random traffic.
`default_nettype none

module tb;
    import icw_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [63:0] MAX34 = 64'h3_FFFF_FFFF;
    localparam logic [63:0] MAX24 = 64'hFF_FFFF;
    localparam logic [63:0] MAX20 = 64'hF_FFFF;
    localparam logic [63:0] MAX16 = 64'hFFFF;
    localparam int IDLE_PCT       = 19;
    localparam int RANDOM_WORDS   = 310;
    localparam int CFG_SETTLE     = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        logic [MODE_W-1:0]    mode;
        logic [TIME_IN_W-1:0] start_second;
        logic [DUR_W-1:0]     duration_seconds;
        logic [ID_W-1:0]      from_id;
        logic [ID_W-1:0]      to_id;
        logic [IDX_W-1:0]     window_index;
    } req_t;

    typedef struct {
        logic              match;
        logic [ID_W-1:0]   party_from;
        logic [ID_W-1:0]   party_to;
        logic [SLOT_W-1:0] slot_number;
        logic [STAT_W-1:0] status;
        logic              last;
    } cover_result_t;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_kind_t;

    typedef struct {
        row_kind_t         kind;
        req_t              req;
        reg_index_t        reg_idx;
        logic [63:0]       reg_val;
        bit                typed;
        logic [STAT_W-1:0] typed_status;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    wire  [DATA_W-1:0]  prdata;
    wire                pready;

    icw_item_if   item_ch ();
    icw_result_if res_ch ();

    interval_cover_window_filter_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [63:0] cfg_begin;
    logic [63:0] cfg_wsec;
    logic [63:0] cfg_wcount;
    logic [63:0] tab_start [TABLE_DEPTH_DEF];
    logic [63:0] tab_dur [TABLE_DEPTH_DEF];
    logic [ID_W-1:0] tab_from [TABLE_DEPTH_DEF];
    logic [ID_W-1:0] tab_to [TABLE_DEPTH_DEF];
    int tab_count;

    cover_result_t pending_results [$];
    cover_result_t want_word;
    stim_row_t     plan [$];
    int  fail_count;
    int  quiet_cycles;
    int  word_count;
    bit  steady;

    always #5 clk = ~clk;

    function automatic cover_result_t status_word(logic [STAT_W-1:0] st);
        cover_result_t w;
        w.match       = 1'b0;
        w.party_from  = '0;
        w.party_to    = '0;
        w.slot_number = '0;
        w.status      = st;
        w.last        = 1'b1;
        return w;
    endfunction

    function automatic logic [TIME_IN_W-1:0] rand34();
        return TIME_IN_W'({$urandom(), $urandom()});
    endfunction

    function automatic req_t rand_word(logic [MODE_W-1:0] m);
        req_t r;
        r.mode             = m;
        r.start_second     = rand34();
        r.duration_seconds = DUR_W'($urandom());
        r.from_id          = ID_W'($urandom());
        r.to_id            = ID_W'($urandom());
        r.window_index     = IDX_W'($urandom());
        return r;
    endfunction

    function automatic stim_row_t f_item(logic [MODE_W-1:0] m, logic [63:0] st, logic [63:0] du,
                                         logic [63:0] fr, logic [63:0] to, logic [63:0] idx,
                                         bit typed, logic [STAT_W-1:0] tst);
        stim_row_t row;
        row.kind                 = ROW_WORD;
        row.req.mode             = m;
        row.req.start_second     = TIME_IN_W'(st);
        row.req.duration_seconds = DUR_W'(du);
        row.req.from_id          = ID_W'(fr);
        row.req.to_id            = ID_W'(to);
        row.req.window_index     = IDX_W'(idx);
        row.reg_idx              = REG_BEGIN;
        row.reg_val              = '0;
        row.typed                = typed;
        row.typed_status         = tst;
        return row;
    endfunction

    function automatic stim_row_t f_reg(reg_index_t idx, logic [63:0] val);
        stim_row_t row;
        row         = f_item(MODE_CLEAR, 0, 0, 0, 0, 0, 1'b0, STAT_OK);
        row.kind    = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic bit idle_draw();
        return !steady && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    task automatic cover_window(input req_t r, output cover_result_t outs [$]);
        logic [63:0] t_lo;
        logic [63:0] t_hi;
        logic [63:0] e;
        cover_result_t w;
        outs.delete();
        case (r.mode)
            MODE_CLEAR:
            begin
                tab_count = 0;
                outs.push_back(status_word(STAT_OK));
            end
            MODE_APPEND:
            begin
                if (tab_count >= TABLE_DEPTH_DEF)
                begin
                    outs.push_back(status_word(STAT_FULL));
                end
                else
                begin
                    tab_start[tab_count] = 64'(r.start_second);
                    tab_dur[tab_count]   = 64'(r.duration_seconds);
                    tab_from[tab_count]  = r.from_id;
                    tab_to[tab_count]    = r.to_id;
                    tab_count++;
                    outs.push_back(status_word(STAT_OK));
                end
            end
            MODE_QUERY:
            begin
                if (64'(r.window_index) >= cfg_wcount)
                begin
                    outs.push_back(status_word(STAT_RANGE));
                end
                else
                begin
                    t_lo = cfg_begin + 64'(r.window_index) * cfg_wsec;
                    t_hi = t_lo + cfg_wsec;
                    for (int j = 0; j < tab_count; j++)
                    begin
                        e = tab_start[j] + tab_dur[j];
                        if (tab_start[j] <= t_lo && e >= t_hi)
                        begin
                            w.match       = 1'b1;
                            w.party_from  = tab_from[j];
                            w.party_to    = tab_to[j];
                            w.slot_number = SLOT_W'({1'b0, r.window_index}) + SLOT_W'(1);
                            w.status      = STAT_OK;
                            w.last        = 1'b0;
                            outs.push_back(w);
                        end
                    end
                    if (outs.size() == 0)
                        outs.push_back(status_word(STAT_OK));
                    else
                        outs[outs.size() - 1].last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic push_word(input req_t r, input bit typed, input logic [STAT_W-1:0] tst);
        cover_result_t got [$];
        @(negedge clk);
        while (idle_draw())
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid            <= 1'b1;
        item_ch.mode             <= r.mode;
        item_ch.start_second     <= r.start_second;
        item_ch.duration_seconds <= r.duration_seconds;
        item_ch.from_id          <= r.from_id;
        item_ch.to_id            <= r.to_id;
        item_ch.window_index     <= r.window_index;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        cover_window(r, got);
        if (typed)
            pending_results.push_back(status_word(tst));
        else
            foreach (got[k])
                pending_results.push_back(got[k]);
        if (r.mode != MODE_UNUSED)
            word_count++;
    endtask

    task automatic quiesce();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [63:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 3'b000});
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_BEGIN:  cfg_begin  = val & MAX34;
            REG_WSEC:   cfg_wsec   = val & MAX16;
            REG_WCOUNT: cfg_wcount = val & MAX20;
            default:
            begin
            end
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_scenario(input bit fill);
        logic [63:0] b;
        logic [63:0] ws;
        logic [63:0] wc;
        logic [63:0] t_lo;
        logic [63:0] st;
        logic [63:0] du;
        int n_app;
        int n_q;
        int nwin;
        int w;
        req_t r;
        case ($urandom_range(0, 3))
            0: b = $urandom_range(0, 1000);
            1: b = 64'(rand34());
            2: b = MAX34;
            default: b = $urandom_range(0, 100000);
        endcase
        case ($urandom_range(0, 4))
            0: ws = 1;
            1: ws = MAX16;
            2: ws = $urandom_range(1, 100);
            default: ws = $urandom_range(1, 65535);
        endcase
        case ($urandom_range(0, 5))
            0: wc = 0;
            1: wc = 1;
            2: wc = MAX20;
            3: wc = 64'(IDX_W'($urandom()));
            default: wc = $urandom_range(2, 20);
        endcase
        if (fill && wc == 0)
            wc = 4;
        quiesce();
        write_reg(REG_BEGIN, b);
        write_reg(REG_WSEC, ws);
        write_reg(REG_WCOUNT, wc);
        nwin = (wc < 8) ? int'(wc) : 8;
        if (fill || $urandom_range(0, 99) < 80)
            push_word(rand_word(MODE_CLEAR), 1'b0, STAT_OK);
        if (fill)
            n_app = TABLE_DEPTH_DEF + 2;
        else if ($urandom_range(0, 9) == 0)
            n_app = $urandom_range(30, 64);
        else
            n_app = $urandom_range(1, 16);
        for (int i = 0; i < n_app; i++)
        begin
            if ($urandom_range(0, 99) < 5)
                push_word(rand_word(MODE_UNUSED), 1'b0, STAT_OK);
            r = rand_word(MODE_APPEND);
            if (nwin > 0 && $urandom_range(0, 99) < 75)
            begin
                w = (fill && $urandom_range(0, 99) < 80) ? 0 : $urandom_range(0, nwin - 1);
                t_lo = b + 64'(w) * ws;
                if (t_lo <= MAX34)
                begin
                    st = t_lo - ((t_lo < 4) ? 0 : $urandom_range(0, 3));
                    if ($urandom_range(0, 99) < 15 && t_lo < MAX34)
                        st = t_lo + 1;
                    du = t_lo + ws - st + $urandom_range(0, 2);
                    if ($urandom_range(0, 99) < 15 && du > 0)
                        du = du - 1;
                    if (du > MAX24)
                        du = MAX24;
                    r.start_second     = TIME_IN_W'(st);
                    r.duration_seconds = DUR_W'(du);
                end
            end
            push_word(r, 1'b0, STAT_OK);
        end
        n_q = fill ? 6 : $urandom_range(2, 8);
        for (int i = 0; i < n_q; i++)
        begin
            r = rand_word(MODE_QUERY);
            w = $urandom_range(0, 99);
            if (nwin > 0 && w < 70)
                r.window_index = IDX_W'($urandom_range(0, nwin - 1));
            else if (w < 80)
                r.window_index = (wc > 0 && w < 75) ? IDX_W'(wc - 1) : IDX_W'(wc);
            push_word(r, 1'b0, STAT_OK);
        end
    endtask

    always @(negedge clk)
        res_ch.ready <= !idle_draw();

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                want_word = pending_results.pop_front();
                if (res_ch.match !== want_word.match)
                begin
                    $error("match: expected %0h, got %0h", want_word.match, res_ch.match);
                    fail_count++;
                end
                if (res_ch.party_from !== want_word.party_from)
                begin
                    $error("party_from: expected %0h, got %0h", want_word.party_from,
                           res_ch.party_from);
                    fail_count++;
                end
                if (res_ch.party_to !== want_word.party_to)
                begin
                    $error("party_to: expected %0h, got %0h", want_word.party_to,
                           res_ch.party_to);
                    fail_count++;
                end
                if (res_ch.slot_number !== want_word.slot_number)
                begin
                    $error("slot_number: expected %0h, got %0h", want_word.slot_number,
                           res_ch.slot_number);
                    fail_count++;
                end
                if (res_ch.status !== want_word.status)
                begin
                    $error("status: expected %0h, got %0h", want_word.status, res_ch.status);
                    fail_count++;
                end
                if (res_ch.last !== want_word.last)
                begin
                    $error("last: expected %0h, got %0h", want_word.last, res_ch.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
            || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("interval_cover_window_filter_top verification failed");
            $finish;
        end
    end

    initial
    begin
        clk                      = 1'b0;
        rst_n                    = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        item_ch.valid            = 1'b0;
        item_ch.mode             = MODE_CLEAR;
        item_ch.start_second     = '0;
        item_ch.duration_seconds = '0;
        item_ch.from_id          = '0;
        item_ch.to_id            = '0;
        item_ch.window_index     = '0;
        res_ch.ready             = 1'b0;
        cfg_begin                = 0;
        cfg_wsec                 = 64'(WSEC_RESET);
        cfg_wcount               = 0;
        tab_count                = 0;
        fail_count               = 0;
        quiet_cycles             = 0;
        word_count               = 0;
        steady                   = 1'b0;

        plan.push_back(f_item(MODE_QUERY, 0, 0, 0, 0, 0, 1'b1, STAT_RANGE));
        plan.push_back(f_item(MODE_UNUSED, MAX34, MAX24, MAX16, MAX16, MAX20, 1'b0, STAT_OK));
        plan.push_back(f_item(MODE_CLEAR, 0, 0, 0, 0, 0, 1'b1, STAT_OK));
        plan.push_back(f_item(MODE_APPEND, 0, 0, 0, MAX16, 0, 1'b1, STAT_OK));
        plan.push_back(f_item(MODE_QUERY, 0, 0, 0, 0, 0, 1'b1, STAT_RANGE));
        plan.push_back(f_reg(REG_BEGIN, 100));
        plan.push_back(f_reg(REG_WSEC, 30));
        plan.push_back(f_reg(REG_WCOUNT, 10));
        plan.push_back(f_item(MODE_APPEND, 100, 300, MAX16, 0, 0, 1'b1, STAT_OK));
        plan.push_back(f_item(MODE_APPEND, MAX34, MAX24, 16'h1234, 16'h4321, 0, 1'b1, STAT_OK));
        plan.push_back(f_item(MODE_APPEND, 130, 30, 16'h00AA, 16'h5500, 0, 1'b1, STAT_OK));
        plan.push_back(f_item(MODE_QUERY, 0, 0, 0, 0, 0, 1'b0, STAT_OK));
        plan.push_back(f_item(MODE_QUERY, 0, 0, 0, 0, 1, 1'b0, STAT_OK));
        plan.push_back(f_item(MODE_QUERY, 0, 0, 0, 0, 9, 1'b0, STAT_OK));
        plan.push_back(f_item(MODE_QUERY, 0, 0, 0, 0, 10, 1'b1, STAT_RANGE));
        plan.push_back(f_item(MODE_QUERY, 0, 0, 0, 0, MAX20, 1'b1, STAT_RANGE));
        plan.push_back(f_reg(REG_WSEC, 0));
        plan.push_back(f_item(MODE_QUERY, 0, 0, 0, 0, 2, 1'b0, STAT_OK));
        plan.push_back(f_reg(REG_BEGIN, MAX34));
        plan.push_back(f_reg(REG_WSEC, MAX16));
        plan.push_back(f_reg(REG_WCOUNT, MAX20));
        plan.push_back(f_item(MODE_QUERY, 0, 0, 0, 0, MAX20 - 1, 1'b0, STAT_OK));
        plan.push_back(f_item(MODE_QUERY, 0, 0, 0, 0, 0, 1'b0, STAT_OK));
        plan.push_back(f_item(MODE_CLEAR, 0, 0, 0, 0, 0, 1'b1, STAT_OK));
        plan.push_back(f_item(MODE_QUERY, 0, 0, 0, 0, 0, 1'b1, STAT_OK));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                quiesce();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end
            else
            begin
                push_word(plan[i].req, plan[i].typed, plan[i].typed_status);
            end
        end

        word_count = 0;
        for (int scen = 0; word_count < RANDOM_WORDS; scen++)
        begin
            steady = (scen >= 2 && scen <= 4);
            run_scenario(scen == 0);
        end
        steady = 1'b0;

        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("interval_cover_window_filter_top verification clean");
        else
            $display("interval_cover_window_filter_top verification failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: interval_cover_window_filter_top.f
hw/rtl/icw_pkg.sv
hw/rtl/icw_item_if.sv
hw/rtl/icw_result_if.sv
hw/rtl/icw_ram.sv
hw/rtl/icw_regs.sv
hw/rtl/icw_ctrl.sv
hw/rtl/icw_datapath.sv
hw/rtl/interval_cover_window_filter_top.sv
verif/tb.sv
